>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. They compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/ecsmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ecsmb_pkg;

    localparam logic [2:0] ACT_HOST_CMD    = 3'd0;
    localparam logic [2:0] ACT_HOST_DATA   = 3'd1;
    localparam logic [2:0] ACT_HOST_STATUS = 3'd2;
    localparam logic [2:0] ACT_HOST_READ   = 3'd3;
    localparam logic [2:0] ACT_ENG_WRITE   = 3'd4;
    localparam logic [2:0] ACT_ENG_READ    = 3'd5;

    localparam logic [7:0] CMD_READ     = 8'h80;
    localparam logic [7:0] CMD_WRITE    = 8'h81;
    localparam logic [7:0] STS_CMD      = 8'h08;
    localparam logic [7:0] STS_OBF      = 8'h01;
    localparam logic [7:0] PROTOCOL_REG = 8'h00;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_RD_ADDR = 4'b0010,
        PH_WR_ADDR = 4'b0100,
        PH_WR_DATA = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] wdata;
        logic [7:0] engine_addr;
    } access_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       start_request;
        logic [7:0] start_protocol;
    } reply_t;

    // What the second stage needs to finish one word.
    typedef struct packed {
        logic       use_mem;
        logic       load_obyte;
        logic       use_obyte;
        logic       mem_ok;
        logic [7:0] fixed;
        logic       start;
        logic [7:0] proto;
    } stage_t;

endpackage

`default_nettype wire

>>> rtl/core/ecsmb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ecsmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/acpi_ec_smbus_register_interface_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction   Handshake                    Word
// access    in          access_valid / access_stall  ecsmb_pkg::access_t
// reply     out         reply_valid / reply_stall    ecsmb_pkg::reply_t
//
// One word is accepted per cycle while access_stall is low; its reply is built in the second stage,
// which reads the register file's registered read port, then held in the reply register.
// Reset clears the port state and the per-entry valid bits, so the file reads as zero at once.
// access_stall rises only when the second stage is full and the reply register is stalled.

`include "assert_macros.svh"

module acpi_ec_smbus_register_interface_unit #(
    parameter int REG_COUNT = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                access_valid,
    output      logic                access_stall,
    input  wire ecsmb_pkg::access_t  access,
    output      logic                reply_valid,
    input  wire logic                reply_stall,
    output      ecsmb_pkg::reply_t   reply
);

    localparam int ADDR_W = $clog2(REG_COUNT);
    localparam logic [8:0] REG_LIMIT = 9'(REG_COUNT);

    ecsmb_pkg::phase_t   phase_reg, phase_next;
    logic [7:0]          pend_reg, pend_next;
    logic                obf_reg, obf_next;
    logic                lwc_reg, lwc_next;
    logic [7:0]          obyte_reg;
    logic [REG_COUNT-1:0] valid_reg;

    ecsmb_pkg::stage_t   s1_reg, s1_next;
    logic                s1_valid_reg;

    logic                accept;
    logic                out_ready;
    logic                s1_move;

    logic                mem_we, mem_re;
    logic [7:0]          mem_waddr, mem_raddr;
    logic [7:0]          ram_q;
    logic [7:0]          mem_byte;
    ecsmb_pkg::reply_t   reply_next;

    assign out_ready    = !reply_valid || !reply_stall;
    assign s1_move      = s1_valid_reg && out_ready;
    assign access_stall = s1_valid_reg && !out_ready;
    assign accept       = access_valid && !access_stall;

    always_comb
    begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        obf_next   = obf_reg;
        lwc_next   = lwc_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = access.engine_addr;
        mem_raddr  = access.engine_addr;
        s1_next    = '0;

        case (access.action)
            ecsmb_pkg::ACT_HOST_CMD:
            begin
                lwc_next = 1'b1;
                if (access.wdata == ecsmb_pkg::CMD_READ)
                begin
                    phase_next = ecsmb_pkg::PH_RD_ADDR;
                end
                else if (access.wdata == ecsmb_pkg::CMD_WRITE)
                begin
                    phase_next = ecsmb_pkg::PH_WR_ADDR;
                end
            end
            ecsmb_pkg::ACT_HOST_DATA:
            begin
                case (phase_reg)
                    ecsmb_pkg::PH_RD_ADDR:
                    begin
                        lwc_next           = 1'b0;
                        obf_next           = 1'b1;
                        phase_next         = ecsmb_pkg::PH_IDLE;
                        mem_re             = 1'b1;
                        mem_raddr          = access.wdata;
                        s1_next.load_obyte = 1'b1;
                    end
                    ecsmb_pkg::PH_WR_ADDR:
                    begin
                        lwc_next   = 1'b0;
                        pend_next  = access.wdata;
                        phase_next = ecsmb_pkg::PH_WR_DATA;
                    end
                    ecsmb_pkg::PH_WR_DATA:
                    begin
                        lwc_next   = 1'b0;
                        phase_next = ecsmb_pkg::PH_IDLE;
                        mem_waddr  = pend_reg;
                        if ({1'b0, pend_reg} < REG_LIMIT)
                        begin
                            mem_we = 1'b1;
                            if (pend_reg == ecsmb_pkg::PROTOCOL_REG && access.wdata != 8'd0)
                            begin
                                s1_next.start = 1'b1;
                                s1_next.proto = access.wdata;
                            end
                        end
                    end
                    default:
                    begin
                        // A data word while idle changes no state; its reply reads zero.
                    end
                endcase
            end
            ecsmb_pkg::ACT_HOST_STATUS:
            begin
                s1_next.fixed = (lwc_reg ? ecsmb_pkg::STS_CMD : 8'd0) |
                                (obf_reg ? ecsmb_pkg::STS_OBF : 8'd0);
            end
            ecsmb_pkg::ACT_HOST_READ:
            begin
                obf_next          = 1'b0;
                s1_next.use_obyte = 1'b1;
            end
            ecsmb_pkg::ACT_ENG_WRITE:
            begin
                mem_we = ({1'b0, access.engine_addr} < REG_LIMIT);
            end
            ecsmb_pkg::ACT_ENG_READ:
            begin
                mem_re          = 1'b1;
                s1_next.use_mem = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Entries never written since reset read as zero.
        s1_next.mem_ok = ({1'b0, mem_raddr} < REG_LIMIT) && valid_reg[mem_raddr[ADDR_W-1:0]];
    end

    ecsmb_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .clk   (clk),
        .we    (accept && mem_we),
        .waddr (mem_waddr[ADDR_W-1:0]),
        .wdata (access.wdata),
        .re    (accept && mem_re),
        .raddr (mem_raddr[ADDR_W-1:0]),
        .rdata (ram_q)
    );

    assign mem_byte = s1_reg.mem_ok ? ram_q : 8'd0;

    always_comb
    begin
        reply_next.start_request  = s1_reg.start;
        reply_next.start_protocol = s1_reg.proto;
        if (s1_reg.use_mem)
        begin
            reply_next.rdata = mem_byte;
        end
        else if (s1_reg.use_obyte)
        begin
            reply_next.rdata = obyte_reg;
        end
        else
        begin
            reply_next.rdata = s1_reg.fixed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ecsmb_pkg::PH_IDLE;
            pend_reg     <= 8'd0;
            obf_reg      <= 1'b0;
            lwc_reg      <= 1'b0;
            obyte_reg    <= 8'd0;
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
            reply_valid  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                pend_reg  <= pend_next;
                obf_reg   <= obf_next;
                lwc_reg   <= lwc_next;
                if (mem_we)
                begin
                    valid_reg[mem_waddr[ADDR_W-1:0]] <= 1'b1;
                end
            end
            if (s1_move && s1_reg.load_obyte)
            begin
                obyte_reg <= mem_byte;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_ready)
            begin
                reply_valid <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            reply <= reply_next;
        end
    end

    `ASSERT_IMPLIES(a_stall_needs_full, clk, rst_n, access_stall, s1_valid_reg && reply_valid)
    `ASSERT_IMPLIES(a_start_nonzero, clk, rst_n, reply_valid && reply.start_request,
                    reply.start_protocol != 8'd0 && reply.rdata == 8'd0)
    `ASSERT_NEXT(a_read_addr_loads, clk, rst_n,
                 accept && access.action == ecsmb_pkg::ACT_HOST_DATA &&
                 phase_reg == ecsmb_pkg::PH_RD_ADDR,
                 s1_valid_reg && s1_reg.load_obyte && obf_reg)
    `ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_reg && !out_ready,
                 s1_valid_reg && $stable(s1_reg))

endmodule

`default_nettype wire

>>> tb/acpi_ec_smbus_register_interface_checker.sv
`timescale 1ns / 1ps

module acpi_ec_smbus_register_interface_checker #(
    parameter int REG_COUNT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                access_valid,
    input  logic                access_stall,
    input  ecsmb_pkg::access_t  access,
    input  logic                reply_valid,
    input  logic                reply_stall,
    input  ecsmb_pkg::reply_t   reply,
    output int                  mismatches,
    output int                  outstanding,
    output int                  compared,
    output int                  starts
);
    import ecsmb_pkg::*;

    phase_t     host_phase;
    logic [7:0] wr_addr;
    logic [7:0] obyte;
    logic       obf;
    logic       cmd_flag;
    logic [7:0] regs [REG_COUNT];
    reply_t     replies_due [$];

    function automatic logic [7:0] file_read(logic [7:0] addr);
        if (addr < REG_COUNT)
        begin
            return regs[addr];
        end
        return 8'h00;
    endfunction

    // Applies one word to the predicted port state and returns the reply it must produce.
    function automatic reply_t access_outcome(access_t w);
        reply_t r;
        r = '0;
        case (w.action)
            ACT_HOST_CMD:
            begin
                cmd_flag = 1'b1;
                if (w.wdata == CMD_READ)
                begin
                    host_phase = PH_RD_ADDR;
                end
                else if (w.wdata == CMD_WRITE)
                begin
                    host_phase = PH_WR_ADDR;
                end
            end
            ACT_HOST_DATA:
            begin
                case (host_phase)
                    PH_RD_ADDR:
                    begin
                        cmd_flag   = 1'b0;
                        obyte      = file_read(w.wdata);
                        obf        = 1'b1;
                        host_phase = PH_IDLE;
                    end
                    PH_WR_ADDR:
                    begin
                        cmd_flag   = 1'b0;
                        wr_addr    = w.wdata;
                        host_phase = PH_WR_DATA;
                    end
                    PH_WR_DATA:
                    begin
                        cmd_flag = 1'b0;
                        if (wr_addr < REG_COUNT)
                        begin
                            regs[wr_addr] = w.wdata;
                            if (wr_addr == PROTOCOL_REG && w.wdata != 8'h00)
                            begin
                                r.start_request  = 1'b1;
                                r.start_protocol = w.wdata;
                            end
                        end
                        host_phase = PH_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ACT_HOST_STATUS:
            begin
                r.rdata = (cmd_flag ? STS_CMD : 8'h00) | (obf ? STS_OBF : 8'h00);
            end
            ACT_HOST_READ:
            begin
                r.rdata = obyte;
                obf     = 1'b0;
            end
            ACT_ENG_WRITE:
            begin
                if (w.engine_addr < REG_COUNT)
                begin
                    regs[w.engine_addr] = w.wdata;
                end
            end
            ACT_ENG_READ:
            begin
                r.rdata = file_read(w.engine_addr);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        reply_t want;
        if (!rst_n)
        begin
            host_phase = PH_IDLE;
            wr_addr    = 8'h00;
            obyte      = 8'h00;
            obf        = 1'b0;
            cmd_flag   = 1'b0;
            foreach (regs[i])
            begin
                regs[i] = 8'h00;
            end
            replies_due.delete();
            mismatches = 0;
            compared   = 0;
            starts     = 0;
        end
        else
        begin
            // The reply side is checked first so that a word accepted in this
            // cycle can never be matched against a reply from this cycle.
            if (reply_valid && !reply_stall)
            begin
                compared++;
                if (reply.start_request === 1'b1)
                begin
                    starts++;
                end
                if (replies_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected reply word, expected none, actual %h",
                             $time, reply);
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (reply.rdata !== want.rdata)
                    begin
                        mismatches++;
                        $display("%0t: rdata mismatch, expected %02h, actual %02h",
                                 $time, want.rdata, reply.rdata);
                    end
                    if (reply.start_request !== want.start_request)
                    begin
                        mismatches++;
                        $display("%0t: start_request mismatch, expected %b, actual %b",
                                 $time, want.start_request, reply.start_request);
                    end
                    if (reply.start_protocol !== want.start_protocol)
                    begin
                        mismatches++;
                        $display("%0t: start_protocol mismatch, expected %02h, actual %02h",
                                 $time, want.start_protocol, reply.start_protocol);
                    end
                end
            end
            if (access_valid && !access_stall)
            begin
                replies_due.push_back(access_outcome(access));
            end
        end
        outstanding = replies_due.size();
    end

endmodule

>>> tb/tb_acpi_ec_smbus_register_interface_unit.sv
`timescale 1ns / 1ps

module tb_acpi_ec_smbus_register_interface_unit;
    import ecsmb_pkg::*;

    localparam int REG_COUNT   = 64;
    localparam int QUIET_LIMIT = 5000;

    logic    clk;
    logic    rst_n;
    logic    access_valid;
    logic    access_stall;
    access_t access;
    logic    reply_valid;
    logic    reply_stall;
    reply_t  reply;

    int tx_idle_pct;
    int rx_idle_pct;
    int words_sent;
    int quiet_cycles;
    int mismatches;
    int outstanding;
    int compared;
    int starts;

    acpi_ec_smbus_register_interface_unit #(
        .REG_COUNT(REG_COUNT)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .access_valid(access_valid),
        .access_stall(access_stall),
        .access      (access),
        .reply_valid (reply_valid),
        .reply_stall (reply_stall),
        .reply       (reply)
    );

    acpi_ec_smbus_register_interface_checker #(
        .REG_COUNT(REG_COUNT)
    ) port_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .access_valid(access_valid),
        .access_stall(access_stall),
        .access      (access),
        .reply_valid (reply_valid),
        .reply_stall (reply_stall),
        .reply       (reply),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared),
        .starts      (starts)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
    begin
        reply_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Ends the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((access_valid && !access_stall) || (reply_valid && !reply_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog, no word moved in %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one word after an optional random idle stretch and holds it until taken.
    task automatic put(logic [2:0] act, logic [7:0] data, logic [7:0] eaddr);
        access_t w;
        w.action      = act;
        w.wdata       = data;
        w.engine_addr = eaddr;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            access_valid <= 1'b0;
            @(negedge clk);
        end
        access_valid <= 1'b1;
        access       <= w;
        do
        begin
            @(posedge clk);
        end
        while (access_stall);
        if (act <= ACT_ENG_READ)
        begin
            words_sent++;
        end
    endtask

    function automatic logic [7:0] pick_addr();
        if ($urandom_range(0, 9) < 8)
        begin
            return 8'($urandom_range(0, REG_COUNT - 1));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            return 8'h00;
        end
        else if (roll < 25)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic directed_corners();
        logic [7:0] top_addr;
        top_addr = 8'(REG_COUNT - 1);
        put(ACT_HOST_STATUS, 8'h00, 8'h00);
        put(ACT_HOST_DATA, 8'hFF, 8'hFF);
        put(ACT_HOST_CMD, 8'h00, 8'h00);
        put(ACT_HOST_STATUS, 8'h00, 8'h00);
        put(ACT_ENG_WRITE, 8'hFF, top_addr);
        put(ACT_ENG_WRITE, 8'hAA, 8'hFF);
        put(ACT_ENG_READ, 8'h00, 8'hFF);
        put(ACT_ENG_READ, 8'h00, top_addr);
        put(ACT_HOST_CMD, CMD_READ, 8'h00);
        put(ACT_HOST_DATA, top_addr, 8'h00);
        put(ACT_HOST_STATUS, 8'h00, 8'h00);
        put(ACT_HOST_READ, 8'h00, 8'h00);
        // A second data read with OBF already clear returns the same byte.
        put(ACT_HOST_READ, 8'h00, 8'h00);
        put(ACT_HOST_CMD, CMD_WRITE, 8'h00);
        put(ACT_HOST_DATA, PROTOCOL_REG, 8'h00);
        put(ACT_HOST_DATA, 8'h24, 8'h00);
        put(ACT_HOST_CMD, CMD_WRITE, 8'h00);
        put(ACT_HOST_DATA, PROTOCOL_REG, 8'h00);
        put(ACT_HOST_DATA, 8'h00, 8'h00);
        // A read command in the middle of a write transaction abandons it and starts a read.
        put(ACT_HOST_CMD, CMD_WRITE, 8'h00);
        put(ACT_HOST_CMD, CMD_READ, 8'h00);
        put(ACT_HOST_DATA, PROTOCOL_REG, 8'h00);
        put(ACT_HOST_CMD, CMD_WRITE, 8'h00);
        put(ACT_HOST_DATA, 8'hFF, 8'h00);
        put(ACT_HOST_DATA, 8'h55, 8'h00);
        put(ACT_ENG_WRITE, 8'h08, PROTOCOL_REG);
        put(3'd6, 8'hFF, 8'hFF);
        put(3'd7, 8'hFF, 8'hFF);
    endtask

    task automatic random_traffic(int target);
        int         pick;
        logic [7:0] addr;
        while (words_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                put(ACT_HOST_CMD, CMD_READ, any_byte());
                put(ACT_HOST_DATA, pick_addr(), any_byte());
                if ($urandom_range(0, 1) == 0)
                begin
                    put(ACT_HOST_STATUS, any_byte(), any_byte());
                end
                put(ACT_HOST_READ, any_byte(), any_byte());
            end
            else if (pick < 50)
            begin
                addr = ($urandom_range(0, 2) == 0) ? PROTOCOL_REG : pick_addr();
                put(ACT_HOST_CMD, CMD_WRITE, any_byte());
                put(ACT_HOST_DATA, addr, any_byte());
                put(ACT_HOST_DATA, pick_byte(), any_byte());
            end
            else if (pick < 65)
            begin
                put(ACT_ENG_WRITE, pick_byte(), pick_addr());
            end
            else if (pick < 78)
            begin
                put(ACT_ENG_READ, any_byte(), pick_addr());
            end
            else if (pick < 85)
            begin
                put($urandom_range(0, 1) ? ACT_HOST_STATUS : ACT_HOST_READ,
                    any_byte(), any_byte());
            end
            else if (pick < 93)
            begin
                // Transactions that are abandoned or restarted part way.
                put(ACT_HOST_CMD, $urandom_range(0, 1) ? CMD_WRITE : CMD_READ, any_byte());
                if ($urandom_range(0, 1) == 0)
                begin
                    put(ACT_HOST_DATA, pick_addr(), any_byte());
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    put(ACT_ENG_WRITE, pick_byte(), pick_addr());
                end
                put(ACT_HOST_CMD, $urandom_range(0, 1) ? CMD_READ : any_byte(), any_byte());
                put(ACT_HOST_DATA, pick_addr(), any_byte());
                put(ACT_HOST_STATUS, any_byte(), any_byte());
            end
            else
            begin
                put(3'($urandom_range(0, 7)),
                    $urandom_range(0, 3) == 0 ? CMD_WRITE : any_byte(), any_byte());
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        access_valid = 1'b0;
        access       = '0;
        reply_stall  = 1'b0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        words_sent   = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_corners();

        tx_idle_pct = 6;
        rx_idle_pct = 58;
        random_traffic(410);
        tx_idle_pct = 58;
        rx_idle_pct = 6;
        random_traffic(790);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(1150);

        @(negedge clk);
        access_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d accesses: port corner cases, then host and engine traffic",
                 words_sent);
        $display("under three idling profiles; %0d replies compared, %0d start requests.",
                 compared, starts);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
